### design/assert_macros.svh
// Concurrent assertion helpers for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/cob_pkg.sv
package cob_pkg;

    localparam int CHAN_W    = 8;
    localparam int QUOT_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int ALPHA_LSB = 24;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [QUOT_W-1:0] quot_t;

endpackage

### design/cob_div_pipe.sv
module cob_div_pipe #(
    parameter int DW = 25
) (
    input  logic                         clk,
    input  logic [DW+cob_pkg::QUOT_W-1:0] numer,
    input  logic [DW-1:0]                denom,
    output cob_pkg::quot_t               quot
);

    localparam int STEPS = cob_pkg::QUOT_W;
    localparam int W     = DW + STEPS;

    logic [W-1:0]          rem_reg [0:STEPS-1];
    logic [DW-1:0]         dv_reg  [0:STEPS-1];
    cob_pkg::quot_t        q_reg   [0:STEPS-1];

    // One quotient bit per stage, most significant first; quotient fits in STEPS bits.
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic [W-1:0]   rem_in;
        logic [DW-1:0]  dv_in;
        cob_pkg::quot_t q_in;
        logic [W-1:0]   dshift;
        logic           take;

        if (i == 0) begin : g_first
            assign rem_in = numer;
            assign dv_in  = denom;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign dv_in  = dv_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        assign dshift = W'(dv_in) << (STEPS - 1 - i);
        assign take   = (rem_in >= dshift);

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= take ? (rem_in - dshift) : rem_in;
            dv_reg[i]  <= dv_in;
            q_reg[i]   <= q_in | (cob_pkg::quot_t'(take) << (STEPS - 1 - i));
        end
    end

    assign quot = q_reg[STEPS-1];

endmodule

### design/coverage_source_over_blend_core.sv
// Pipeline: 4 arithmetic stages, 8 divider stages and one output register lie
// between start and done.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall,
// each divider stage retires one quotient bit for the three color lanes every cycle.
// Alpha divides by a constant through a reciprocal multiply, delayed to match.
// Reset: rst_n clears the valid pipeline asynchronously; in-flight items are dropped.
`include "assert_macros.svh"

module coverage_source_over_blend_core #(
    parameter int COVERAGE_SAMPLES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_color,
    input  logic [31:0] dest_color,
    input  logic [4:0]  coverage,
    output logic        done,
    output logic [31:0] blended_color
);

    localparam int CW     = cob_pkg::CHAN_W;
    localparam int NC     = cob_pkg::NUM_CHAN;
    localparam int STEPS  = cob_pkg::QUOT_W;
    localparam int TOTAL  = 255 * COVERAGE_SAMPLES;
    localparam int TW     = $clog2(TOTAL + 1);
    localparam int CVW    = $clog2(COVERAGE_SAMPLES + 1);
    localparam int SW     = $clog2(255 * TOTAL + 1);
    localparam int PW     = SW + CW;
    localparam int DW     = SW + 1;
    localparam int W      = DW + STEPS;
    localparam int CMPW   = (CVW > 5) ? CVW : 5;
    localparam int DEPTH  = 4 + STEPS;
    localparam int XW     = SW + 2;
    localparam int MW     = XW + 2;
    localparam int PRW    = XW + MW;
    localparam int RK     = XW + TW + 1;

    localparam logic [TW-1:0]   T_VAL   = TW'(TOTAL);
    localparam logic [CVW-1:0]  COV_MAX = CVW'(COVERAGE_SAMPLES);
    localparam longint unsigned RECIP_L = ((64'd1 << RK) + 64'(2 * TOTAL) - 64'd1)
                                          / 64'(2 * TOTAL);
    localparam logic [MW-1:0]   RECIP   = MW'(RECIP_L);

    assign busy = 1'b0;

    // stage 1: saturate coverage, scale source alpha
    logic [CVW-1:0]        cov_sat;
    logic [TW-1:0]         ac_reg;
    cob_pkg::chan_t        ad1_reg;
    cob_pkg::chan_t        cs1_reg [0:NC-1];
    cob_pkg::chan_t        cd1_reg [0:NC-1];

    assign cov_sat = (CMPW'(coverage) > CMPW'(COVERAGE_SAMPLES)) ? COV_MAX
                                                                 : CVW'(coverage);

    always_ff @(posedge clk)
    begin
        ac_reg  <= TW'(source_color[cob_pkg::ALPHA_LSB +: CW]) * TW'(cov_sat);
        ad1_reg <= dest_color[cob_pkg::ALPHA_LSB +: CW];
        for (int k = 0; k < NC; k++)
        begin
            cs1_reg[k] <= source_color[k*CW +: CW];
            cd1_reg[k] <= dest_color[k*CW +: CW];
        end
    end

    // stage 2: source and destination weights
    logic [SW-1:0]   s_reg;
    logic [SW-1:0]   d_reg;
    cob_pkg::chan_t  cs2_reg [0:NC-1];
    cob_pkg::chan_t  cd2_reg [0:NC-1];

    always_ff @(posedge clk)
    begin
        s_reg <= SW'(ac_reg) * SW'(cob_pkg::CHAN_MAX);
        d_reg <= SW'(ad1_reg) * SW'(T_VAL - ac_reg);
        cs2_reg <= cs1_reg;
        cd2_reg <= cd1_reg;
    end

    // stage 3: weighted channel products
    logic [SW-1:0]  sum3_reg;
    logic [PW-1:0]  ps_reg [0:NC-1];
    logic [PW-1:0]  pd_reg [0:NC-1];

    always_ff @(posedge clk)
    begin
        sum3_reg <= s_reg + d_reg;
        for (int k = 0; k < NC; k++)
        begin
            ps_reg[k] <= PW'(cs2_reg[k]) * PW'(s_reg);
            pd_reg[k] <= PW'(cd2_reg[k]) * PW'(d_reg);
        end
    end

    // stage 4: rounded numerators and doubled divisors
    logic [W-1:0]   n_reg [0:NC-1];
    logic [DW-1:0]  dv_reg [0:NC-1];
    logic [XW-1:0]  ax_reg;
    logic           zero4_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NC; k++)
        begin
            n_reg[k]  <= {ps_reg[k] + pd_reg[k], 1'b0} + W'(sum3_reg);
            dv_reg[k] <= {sum3_reg, 1'b0};
        end
        ax_reg     <= {sum3_reg, 1'b0} + XW'(T_VAL);
        zero4_reg  <= (sum3_reg == '0);
    end

    // lanes 0..2 are blue, green, red
    cob_pkg::quot_t quot [0:NC-1];

    for (genvar k = 0; k < NC; k++) begin : g_lane
        cob_div_pipe #(
            .DW (DW)
        ) u_div (
            .clk   (clk),
            .numer (n_reg[k]),
            .denom (dv_reg[k]),
            .quot  (quot[k])
        );
    end

    // alpha: divide by twice the total via reciprocal, then delay to match the lanes
    logic [PRW-1:0]   alpha_prod;
    cob_pkg::quot_t   alpha_dly_reg [0:STEPS-1];

    assign alpha_prod = PRW'(ax_reg) * PRW'(RECIP);

    logic [STEPS-1:0] zero_reg;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [31:0]      out_reg;
    logic             done_reg;

    assign valid_next = {valid_reg[DEPTH-2:0], start};

    always_ff @(posedge clk)
    begin
        zero_reg         <= {zero_reg[STEPS-2:0], zero4_reg};
        alpha_dly_reg[0] <= alpha_prod[RK +: STEPS];
        for (int j = 1; j < STEPS; j++)
        begin
            alpha_dly_reg[j] <= alpha_dly_reg[j-1];
        end
        out_reg  <= zero_reg[STEPS-1] ? '0
                                      : {alpha_dly_reg[STEPS-1], quot[2], quot[1], quot[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[DEPTH-1];
        end
    end

    assign done          = done_reg;
    assign blended_color = out_reg;

    `ASSERT_IMPLIES(a_done_from_start, clk, rst_n, done && $past(rst_n, DEPTH + 1),
                    $past(start, DEPTH + 1))
    `ASSERT_NEXT(a_pipe_advance, clk, rst_n, valid_reg[DEPTH-1], done)
    `ASSERT_IMPLIES(a_zero_output, clk, rst_n, done && $past(zero_reg[STEPS-1]),
                    blended_color == 32'h0)

endmodule
